/* rtl/pte_pkg.sv */
package pte_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_GROUND_HEIGHT = 2'd0;
    localparam logic [1:0] CFG_RANGE_MIN     = 2'd1;
    localparam logic [1:0] CFG_RANGE_MAX     = 2'd2;

    localparam logic signed [23:0] GROUND_RESET    = 24'sd0;
    localparam logic [9:0]         RANGE_MIN_RESET = 10'd20;
    localparam logic [9:0]         RANGE_MAX_RESET = 10'd765;
    localparam logic [6:0]         CM_PER_M        = 7'd100;

    // Width of the atan2 operands and of the rotator datapath.
    localparam int ARG_W    = 34;
    localparam int ROT_W    = 44;
    localparam int NORM_BIT = 38;
    localparam int SQ_W     = 62;
    localparam int SQ_STEPS = 31;

    localparam int ATAN_TAB_LEN = 24;
    localparam logic [31:0] ATAN_TAB [ATAN_TAB_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680350,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Operands that ride alongside the square root stages.
    typedef struct packed {
        logic signed [ARG_W-1:0] roll_y;
        logic signed [ARG_W-1:0] roll_x;
        logic signed [ARG_W-1:0] yaw_y;
        logic signed [ARG_W-1:0] yaw_x;
        logic signed [31:0]      sin_p;
        logic [9:0]              cm;
    } carry_t;

endpackage

/* rtl/pte_cordic.sv */
module pte_cordic #(
    parameter int STEPS = 16
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [pte_pkg::ARG_W-1:0] in_y,
    input  logic signed [pte_pkg::ARG_W-1:0] in_x,
    output logic signed [15:0]               out_ang
);

    localparam int AW = pte_pkg::ARG_W;
    localparam int RW = pte_pkg::ROT_W;

    logic [AW-1:0]          mag_x;
    logic [AW-1:0]          mag_y;
    logic [AW-1:0]          mag_or;
    logic [5:0]             msb;
    logic [5:0]             shamt;

    logic signed [AW-1:0]   n1_x_reg;
    logic signed [AW-1:0]   n1_y_reg;
    logic [5:0]             n1_sh_reg;
    logic                   n1_zero_reg;
    logic signed [RW-1:0]   n2_x_reg;
    logic signed [RW-1:0]   n2_y_reg;
    logic                   n2_zero_reg;

    logic signed [RW-1:0]   cx_reg [0:STEPS];
    logic signed [RW-1:0]   cy_reg [0:STEPS];
    logic [31:0]            ca_reg [0:STEPS];
    logic                   cz_reg [0:STEPS];
    logic [31:0]            rnd;
    logic signed [15:0]     ang_reg;

    always_comb begin
        mag_x  = in_x[AW-1] ? AW'(-in_x) : AW'(in_x);
        mag_y  = in_y[AW-1] ? AW'(-in_y) : AW'(in_y);
        mag_or = mag_x | mag_y;
        msb    = '0;
        for (int i = 0; i < AW; i++) begin
            if (mag_or[i]) begin
                msb = 6'(i);
            end
        end
        shamt = 6'(pte_pkg::NORM_BIT) - msb;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_x_reg    <= in_x;
            n1_y_reg    <= in_y;
            n1_sh_reg   <= shamt;
            n1_zero_reg <= (mag_or == '0);

            n2_x_reg    <= RW'(n1_x_reg) <<< n1_sh_reg;
            n2_y_reg    <= RW'(n1_y_reg) <<< n1_sh_reg;
            n2_zero_reg <= n1_zero_reg;

            // Fold the left half plane over so the rotation starts near zero.
            if (n2_x_reg < 0) begin
                cx_reg[0] <= -n2_x_reg;
                cy_reg[0] <= -n2_y_reg;
                ca_reg[0] <= 32'h8000_0000;
            end else begin
                cx_reg[0] <= n2_x_reg;
                cy_reg[0] <= n2_y_reg;
                ca_reg[0] <= 32'h0;
            end
            cz_reg[0] <= n2_zero_reg;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                if (cy_reg[i] >= 0) begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    ca_reg[i+1] <= ca_reg[i] + pte_pkg::ATAN_TAB[i];
                end else begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    ca_reg[i+1] <= ca_reg[i] - pte_pkg::ATAN_TAB[i];
                end
                cz_reg[i+1] <= cz_reg[i];
            end
        end
    end

    assign rnd = ca_reg[STEPS] + 32'h0000_8000;

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg <= cz_reg[STEPS] ? 16'sd0 : $signed(rnd[31:16]);
        end
    end

    assign out_ang = ang_reg;

endmodule

/* rtl/pose_to_euler_and_range.sv */
// Throughput: one pose per cycle unless the result is stalled; the products, a
// 31-stage square root and three CORDIC pipelines of CORDIC_STEPS stages each take
// a new item every cycle. A stalled result freezes the whole pipeline; bubbles
// travel as cleared valid bits. Reset (synchronous, active low) clears all valid
// bits and loads the register defaults: ground height 0, minimum range 20 cm,
// maximum range 765 cm.
module pose_to_euler_and_range #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_addr,
    input  logic [23:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_quat_w,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    input  logic signed [23:0] s_height,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_roll,
    output logic signed [15:0] m_pitch,
    output logic signed [15:0] m_yaw,
    output logic [9:0]         m_range_cm
);

    localparam int AW     = pte_pkg::ARG_W;
    localparam int SW     = pte_pkg::SQ_W;
    localparam int NSQ    = pte_pkg::SQ_STEPS;
    localparam int CLAT   = CORDIC_STEPS + 4;
    localparam int DEPTH  = 4 + NSQ + CLAT;

    logic signed [23:0] ground_reg;
    logic [9:0]         rmin_reg;
    logic [9:0]         rmax_reg;

    logic               en;
    logic [DEPTH-1:0]   vld_reg;

    logic signed [31:0] p_yz_reg, p_wx_reg, p_ww_reg, p_xx_reg, p_yy_reg;
    logic signed [31:0] p_zz_reg, p_xy_reg, p_wz_reg, p_wy_reg, p_zx_reg;
    logic signed [24:0] d_reg;

    logic signed [AW-1:0] ry_reg, rx_reg, yy_reg, yx_reg;
    logic signed [31:0]   s_reg;
    logic [22:0]          cmr_reg;

    logic signed [AW-1:0] s_full;
    logic signed [31:0]   s_sat;
    logic signed [31:0]   d_scaled;
    logic [9:0]           cm_lo;
    logic [9:0]           cm_cl;

    logic [SW-1:0]        ss_reg;
    logic [SW-1:0]        sq_v_reg [0:NSQ];
    logic [SW-1:0]        sq_r_reg [0:NSQ];
    pte_pkg::carry_t      carry_reg [0:NSQ+1];
    logic [9:0]           cm_dly_reg [0:CLAT-1];

    logic signed [AW-1:0] cos_p;
    logic signed [15:0]   roll_ang, pitch_ang, yaw_ang;

    assign cfg_ready = 1'b1;
    assign en        = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready   = en;
    assign m_valid   = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ground_reg <= pte_pkg::GROUND_RESET;
            rmin_reg   <= pte_pkg::RANGE_MIN_RESET;
            rmax_reg   <= pte_pkg::RANGE_MAX_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                pte_pkg::CFG_GROUND_HEIGHT: ground_reg <= $signed(cfg_data);
                pte_pkg::CFG_RANGE_MIN:     rmin_reg   <= cfg_data[9:0];
                pte_pkg::CFG_RANGE_MAX:     rmax_reg   <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
        end
    end

    always_comb begin
        s_full   = 34'sd2 * (AW'(p_wy_reg) - AW'(p_zx_reg));
        s_sat    = 32'(s_full);
        if (s_full > 34'sd1073741824) begin
            s_sat = 32'sd1073741824;
        end else if (s_full < -34'sd1073741824) begin
            s_sat = -32'sd1073741824;
        end
        d_scaled = 32'(d_reg) * 32'(signed'({1'b0, pte_pkg::CM_PER_M}));
        cm_lo    = (cmr_reg < 23'(rmin_reg)) ? rmin_reg : 10'(cmr_reg);
        if (cmr_reg < 23'(rmin_reg)) begin
            cm_lo = rmin_reg;
        end else if (cmr_reg > 23'(rmax_reg)) begin
            cm_lo = rmax_reg;
        end
        cm_cl    = (cm_lo > rmax_reg) ? rmax_reg : cm_lo;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_yz_reg <= s_quat_y * s_quat_z;
            p_wx_reg <= s_quat_w * s_quat_x;
            p_ww_reg <= s_quat_w * s_quat_w;
            p_xx_reg <= s_quat_x * s_quat_x;
            p_yy_reg <= s_quat_y * s_quat_y;
            p_zz_reg <= s_quat_z * s_quat_z;
            p_xy_reg <= s_quat_x * s_quat_y;
            p_wz_reg <= s_quat_w * s_quat_z;
            p_wy_reg <= s_quat_w * s_quat_y;
            p_zx_reg <= s_quat_z * s_quat_x;
            d_reg    <= 25'(s_height) - 25'(ground_reg);

            ry_reg  <= 34'sd2 * (AW'(p_yz_reg) + AW'(p_wx_reg));
            rx_reg  <= AW'(p_ww_reg) - AW'(p_xx_reg) - AW'(p_yy_reg) + AW'(p_zz_reg);
            yy_reg  <= 34'sd2 * (AW'(p_xy_reg) + AW'(p_wz_reg));
            yx_reg  <= AW'(p_ww_reg) + AW'(p_xx_reg) - AW'(p_yy_reg) - AW'(p_zz_reg);
            s_reg   <= s_sat;
            // Below ground reads as zero before the clamp.
            cmr_reg <= d_reg[24] ? 23'd0 : 23'(d_scaled >>> 8);

            ss_reg              <= SW'(s_reg * s_reg);
            carry_reg[0].roll_y <= ry_reg;
            carry_reg[0].roll_x <= rx_reg;
            carry_reg[0].yaw_y  <= yy_reg;
            carry_reg[0].yaw_x  <= yx_reg;
            carry_reg[0].sin_p  <= s_reg;
            carry_reg[0].cm     <= cm_cl;

            sq_v_reg[0]  <= (SW'(1) << 60) - ss_reg;
            sq_r_reg[0]  <= '0;
            carry_reg[1] <= carry_reg[0];
        end
    end

    // One digit of the bitwise square root per stage, largest digit first.
    for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
        localparam logic [SW-1:0] BIT = SW'(1) << (60 - 2 * i);
        always_ff @(posedge aclk) begin
            if (en) begin
                if (sq_v_reg[i] >= sq_r_reg[i] + BIT) begin
                    sq_v_reg[i+1] <= sq_v_reg[i] - (sq_r_reg[i] + BIT);
                    sq_r_reg[i+1] <= (sq_r_reg[i] >> 1) + BIT;
                end else begin
                    sq_v_reg[i+1] <= sq_v_reg[i];
                    sq_r_reg[i+1] <= sq_r_reg[i] >> 1;
                end
                carry_reg[i+2] <= carry_reg[i+1];
            end
        end
    end

    assign cos_p = AW'(sq_r_reg[NSQ]);

    pte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
        .aclk(aclk), .en(en),
        .in_y(carry_reg[NSQ+1].roll_y), .in_x(carry_reg[NSQ+1].roll_x),
        .out_ang(roll_ang)
    );

    pte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .aclk(aclk), .en(en),
        .in_y(AW'(carry_reg[NSQ+1].sin_p)), .in_x(cos_p),
        .out_ang(pitch_ang)
    );

    pte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
        .aclk(aclk), .en(en),
        .in_y(carry_reg[NSQ+1].yaw_y), .in_x(carry_reg[NSQ+1].yaw_x),
        .out_ang(yaw_ang)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            cm_dly_reg[0] <= carry_reg[NSQ+1].cm;
            for (int i = 1; i < CLAT; i++) begin
                cm_dly_reg[i] <= cm_dly_reg[i-1];
            end
        end
    end

    assign m_roll     = roll_ang;
    assign m_yaw      = yaw_ang;
    assign m_pitch    = (pitch_ang > 16'sd16384)  ? 16'sd16384  :
                        (pitch_ang < -16'sd16384) ? -16'sd16384 : pitch_ang;
    assign m_range_cm = cm_dly_reg[CLAT-1];

endmodule

/* rtl/pte_checker.sv */
module pte_props (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_roll,
    input logic signed [15:0] m_pitch,
    input logic signed [15:0] m_yaw,
    input logic [9:0]         m_range_cm
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_roll) && $stable(m_pitch)
            && $stable(m_yaw) && $stable(m_range_cm))
        else $error("stalled result changed");

    a_stall_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while the pipeline is stalled");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pitch <= 16'sd16384) && (m_pitch >= -16'sd16384))
        else $error("pitch beyond a quarter turn");

endmodule

bind pose_to_euler_and_range pte_props u_pte_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready), .m_valid(m_valid),
    .m_ready(m_ready), .m_roll(m_roll), .m_pitch(m_pitch), .m_yaw(m_yaw),
    .m_range_cm(m_range_cm)
);

/* verif/pte_checker.sv */
module pte_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_addr,
    input  logic [23:0]        cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_quat_w,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    input  logic signed [23:0] s_height,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_roll,
    input  logic signed [15:0] m_pitch,
    input  logic signed [15:0] m_yaw,
    input  logic [9:0]         m_range_cm,
    output int                 fail_count,
    output int                 pending,
    output int                 result_count
);

    localparam int STEPS = 16;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic [9:0]         range_cm;
    } attitude_t;

    attitude_t         attitude_q[$];
    logic signed [23:0] ground_q;
    logic [9:0]         min_cm;
    logic [9:0]         max_cm;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] binary_angle(longint yv, longint xv);
        logic [31:0] ang;
        longint dx, dy;
        ang = 32'd0;
        if (xv == 0 && yv == 0) return 32'd0;
        while ((xv < 0 ? -xv : xv) < (64'sd1 <<< 38) &&
               (yv < 0 ? -yv : yv) < (64'sd1 <<< 38)) begin
            xv = xv * 2;
            yv = yv * 2;
        end
        if (xv < 0) begin
            xv = -xv;
            yv = -yv;
            ang = 32'h8000_0000;
        end
        for (int i = 0; i < STEPS && i < pte_pkg::ATAN_TAB_LEN; i++) begin
            dx = shr_floor(yv, i);
            dy = shr_floor(xv, i);
            if (yv >= 0) begin
                xv += dx;
                yv -= dy;
                ang += pte_pkg::ATAN_TAB[i];
            end else begin
                xv -= dx;
                yv += dy;
                ang -= pte_pkg::ATAN_TAB[i];
            end
        end
        return ang;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic logic signed [15:0] to_angle16(logic [31:0] a);
        logic [31:0] r;
        r = a + 32'h8000;
        return r[31:16];
    endfunction

    function automatic attitude_t expected_attitude(longint w, longint x, longint y, longint z,
                                                    longint h);
        attitude_t r;
        longint s, c, d, cm;
        int p;
        r.roll = to_angle16(binary_angle(2 * (y * z + w * x), w * w - x * x - y * y + z * z));
        r.yaw  = to_angle16(binary_angle(2 * (x * y + w * z), w * w + x * x - y * y - z * z));
        s = 2 * (w * y - z * x);
        if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
        if (s < -(64'sd1 <<< 30)) s = -(64'sd1 <<< 30);
        c = int_sqrt((64'd1 << 60) - longint'(s * s));
        p = to_angle16(binary_angle(s, c));
        if (p > 16384) p = 16384;
        if (p < -16384) p = -16384;
        r.pitch = 16'(p);
        d = h - longint'(ground_q);
        cm = d < 0 ? 0 : (d * 100) >>> 8;
        if (cm < longint'(min_cm)) cm = longint'(min_cm);
        if (cm > longint'(max_cm)) cm = longint'(max_cm);
        r.range_cm = cm[9:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        attitude_t got, want;
        if (!aresetn) begin
            ground_q <= pte_pkg::GROUND_RESET;
            min_cm   <= pte_pkg::RANGE_MIN_RESET;
            max_cm   <= pte_pkg::RANGE_MAX_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    pte_pkg::CFG_GROUND_HEIGHT: ground_q <= cfg_data;
                    pte_pkg::CFG_RANGE_MIN:     min_cm   <= cfg_data[9:0];
                    pte_pkg::CFG_RANGE_MAX:     max_cm   <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                attitude_q.push_back(expected_attitude(s_quat_w, s_quat_x, s_quat_y,
                                                       s_quat_z, s_height));
            if (m_valid && m_ready) begin
                got = '{m_roll, m_pitch, m_yaw, m_range_cm};
                result_count <= result_count + 1;
                if (attitude_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = attitude_q.pop_front();
                    if (got.roll !== want.roll || got.pitch !== want.pitch ||
                        got.yaw !== want.yaw || got.range_cm !== want.range_cm) begin
                        $display({"%0t: expected roll %0d pitch %0d yaw %0d range %0d, ",
                                  "got %0d %0d %0d %0d"},
                                 $time, want.roll, want.pitch, want.yaw, want.range_cm,
                                 got.roll, got.pitch, got.yaw, got.range_cm);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending = attitude_q.size();
    end

    initial begin
        fail_count = 0;
        pending = 0;
        result_count = 0;
    end
endmodule

/* verif/tb.sv */
module tb;

    localparam int LATENCY = 55;
    localparam int CYCLE_LIMIT = 400000;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid, cfg_ready;
    logic [1:0]         cfg_addr;
    logic [23:0]        cfg_data;
    logic               s_valid, s_ready;
    logic signed [15:0] s_quat_w, s_quat_x, s_quat_y, s_quat_z;
    logic signed [23:0] s_height;
    logic               m_valid, m_ready;
    logic signed [15:0] m_roll, m_pitch, m_yaw;
    logic [9:0]         m_range_cm;
    int                 fail_count, pending, result_count, cycles, pose_count;

    pose_to_euler_and_range u_dut (.*);

    pte_checker u_checker (.*);

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb failed");
            $finish;
        end
    end

    // Random stalls on the result side; some stretches run with no stall.
    initial begin
        int hold;
        m_ready = 0;
        forever begin
            @(negedge aclk);
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            m_ready = 0;
            repeat (hold) @(negedge aclk);
            m_ready = 1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        @(negedge aclk);
        cfg_valid = 1;
        cfg_addr  = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    task automatic send_pose(logic signed [15:0] w, x, y, z, logic signed [23:0] h,
                             int gap);
        repeat (gap) @(negedge aclk);
        s_valid  = 1;
        s_quat_w = w;
        s_quat_x = x;
        s_quat_y = y;
        s_quat_z = z;
        s_height = h;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 0;
        pose_count++;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    // Random unit quaternion, or occasionally raw bit patterns.
    task automatic random_pose(int gap_max);
        real a, b, c, d, n;
        logic signed [15:0] w, x, y, z;
        logic signed [23:0] h;
        if ($urandom_range(0, 9) == 0) begin
            w = 16'($urandom); x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
        end else begin
            a = $itor($signed($urandom_range(0, 65535)) - 32768);
            b = $itor($signed($urandom_range(0, 65535)) - 32768);
            c = $itor($signed($urandom_range(0, 65535)) - 32768);
            d = $itor($signed($urandom_range(0, 65535)) - 32768);
            n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
            w = 16'($rtoi(a / n * 32767.0));
            x = 16'($rtoi(b / n * 32767.0));
            y = 16'($rtoi(c / n * 32767.0));
            z = 16'($rtoi(d / n * 32767.0));
        end
        h = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 2200) - 200);
        send_pose(w, x, y, z, h, $urandom_range(0, 1) ? 0 : $urandom_range(0, gap_max));
    endtask

    initial begin
        cfg_valid = 0; cfg_addr = pte_pkg::CFG_GROUND_HEIGHT; cfg_data = 0;
        s_valid = 0; s_quat_w = 0; s_quat_x = 0; s_quat_y = 0; s_quat_z = 0; s_height = 0;
        cycles = 0;
        pose_count = 0;
        aresetn = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed: identity, zero quaternion, axes, gimbal lock, pi angles, height extremes.
        send_pose(16'sd32767, 0, 0, 0, 24'sd1000, 0);
        send_pose(0, 0, 0, 0, 0, 0);
        send_pose(16'sh8000, 0, 0, 0, 24'sh800000, 1);
        send_pose(0, 16'sd32767, 0, 0, 24'sh7FFFFF, 0);
        send_pose(0, 0, 16'sd32767, 0, -24'sd1, 0);
        send_pose(0, 0, 0, 16'sd32767, 24'sd51, 2);
        send_pose(16'sd23170, 0, 16'sd23170, 0, 24'sd512, 0);
        send_pose(16'sd23170, 0, -16'sd23170, 0, 24'sd512, 0);
        send_pose(16'sd23170, 16'sd23170, 0, 0, 24'sd256, 0);
        send_pose(16'sd23170, 0, 0, 16'sd23170, 24'sd1958, 0);
        send_pose(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 24'sd100, 0);
        send_pose(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 24'sd1959, 0);
        send_pose(16'sd32767, 16'sh8000, 16'sd32767, 16'sh8000, 24'sd2000, 0);
        send_pose(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 24'sd52, 3);
        send_pose(-16'sd1, 16'sd1, -16'sd1, 16'sd1, 24'sd53, 0);
        drain();

        // Register sweep: extremes, min above max, ignored index.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(pte_pkg::CFG_GROUND_HEIGHT, 24'h800000);
                    write_reg(pte_pkg::CFG_RANGE_MIN, 24'd0);
                    write_reg(pte_pkg::CFG_RANGE_MAX, 24'd1023);
                end
                1: begin
                    write_reg(pte_pkg::CFG_GROUND_HEIGHT, 24'h7FFFFF);
                    write_reg(pte_pkg::CFG_RANGE_MIN, 24'd1023);
                    write_reg(pte_pkg::CFG_RANGE_MAX, 24'd0);
                end
                2: begin
                    write_reg(pte_pkg::CFG_GROUND_HEIGHT, 24'hFFFF00);
                    write_reg(pte_pkg::CFG_RANGE_MIN, 24'd500);
                    write_reg(pte_pkg::CFG_RANGE_MAX, 24'd100);
                end
                3: begin
                    write_reg(pte_pkg::CFG_GROUND_HEIGHT, 24'd300);
                    write_reg(pte_pkg::CFG_RANGE_MIN, 24'hFFFC05);
                    write_reg(pte_pkg::CFG_RANGE_MAX, 24'h0003FF);
                    write_reg(2'd3, 24'hFFFFFF);
                end
                4: begin
                    write_reg(pte_pkg::CFG_GROUND_HEIGHT, 24'($urandom));
                    write_reg(pte_pkg::CFG_RANGE_MIN, 24'($urandom_range(0, 200)));
                    write_reg(pte_pkg::CFG_RANGE_MAX, 24'($urandom_range(200, 1023)));
                end
                default: begin
                    write_reg(pte_pkg::CFG_GROUND_HEIGHT, 24'd0);
                    write_reg(pte_pkg::CFG_RANGE_MIN, 24'd20);
                    write_reg(pte_pkg::CFG_RANGE_MAX, 24'd765);
                end
            endcase
            for (int k = 0; k < 240; k++)
                random_pose(phase == 5 ? 0 : 16);
            drain();
        end

        $display("%0d poses sent, %0d results checked over six register settings",
                 pose_count, result_count);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/pte_pkg.sv
rtl/pte_cordic.sv
rtl/pose_to_euler_and_range.sv
rtl/pte_checker.sv
verif/pte_checker.sv
verif/tb.sv
